/* src/cfd_pkg.sv */
package cfd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CodeMax  = 8'hFF;
  localparam logic [7:0] CodeZero = 8'h00;

  localparam logic [15:0] CapacityReset = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DECODE   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

/* src/cfd_front.sv */
module cfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              frame_last,
  output logic              res_push,
  output cfd_pkg::result_t  res
);

  logic [15:0]      output_capacity;
  logic [7:0]       group_left, group_left_next;
  logic             prior_code_max, prior_code_max_next;
  logic             seen_code, seen_code_next;
  logic [15:0]      written_count, written_count_next;
  cfd_pkg::status_t error_kind, error_kind_next;
  logic             error_in_open_group, error_in_open_group_next;

  logic             at_cap;
  logic             emit;
  logic [7:0]       ob;
  logic             go;
  cfd_pkg::status_t st;

  assign at_cap = written_count >= output_capacity;

  always_comb begin
    group_left_next          = group_left;
    prior_code_max_next      = prior_code_max;
    seen_code_next           = seen_code;
    written_count_next       = written_count;
    error_kind_next          = error_kind;
    error_in_open_group_next = error_in_open_group;
    emit = 1'b0;
    ob   = cfd_pkg::CodeZero;
    go   = 1'b1;
    st   = cfd_pkg::ST_OK;

    if (group_left != 8'd0) begin
      // data byte
      if (error_kind == cfd_pkg::ST_OK) begin
        if (at_cap) begin
          error_kind_next          = cfd_pkg::ST_OVERFLOW;
          error_in_open_group_next = 1'b1;
        end else begin
          emit               = 1'b1;
          ob                 = in_byte;
          written_count_next = written_count + 16'd1;
        end
      end
      group_left_next = group_left - 8'd1;
      if (group_left_next == 8'd0) begin
        error_in_open_group_next = 1'b0;
      end
    end else if (error_kind == cfd_pkg::ST_OK) begin
      // code byte; implicit zero of the previous group goes out first
      if (seen_code && !prior_code_max) begin
        if (at_cap) begin
          error_kind_next = cfd_pkg::ST_OVERFLOW;
          go              = 1'b0;
        end else begin
          emit               = 1'b1;
          written_count_next = written_count + 16'd1;
        end
      end
      if (go) begin
        if (in_byte == cfd_pkg::CodeZero) begin
          error_kind_next = cfd_pkg::ST_DECODE;
        end else begin
          group_left_next     = in_byte - 8'd1;
          prior_code_max_next = (in_byte == cfd_pkg::CodeMax);
          seen_code_next      = 1'b1;
        end
      end
    end

    if (frame_last) begin
      if (group_left_next != 8'd0 &&
          (error_kind_next == cfd_pkg::ST_OK || error_in_open_group_next)) begin
        st = cfd_pkg::ST_DECODE;
      end else begin
        st = error_kind_next;
      end
      group_left_next          = 8'd0;
      prior_code_max_next      = 1'b0;
      seen_code_next           = 1'b0;
      written_count_next       = 16'd0;
      error_kind_next          = cfd_pkg::ST_OK;
      error_in_open_group_next = 1'b0;
    end
  end

  assign res_push      = take && (emit || frame_last);
  assign res.out_byte  = ob;
  assign res.out_valid = emit;
  assign res.frame_end = frame_last;
  assign res.status    = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity     <= cfd_pkg::CapacityReset;
      group_left          <= 8'd0;
      prior_code_max      <= 1'b0;
      seen_code           <= 1'b0;
      written_count       <= 16'd0;
      error_kind          <= cfd_pkg::ST_OK;
      error_in_open_group <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        output_capacity <= cfg_wr_data;
      end
      if (take) begin
        group_left          <= group_left_next;
        prior_code_max      <= prior_code_max_next;
        seen_code           <= seen_code_next;
        written_count       <= written_count_next;
        error_kind          <= error_kind_next;
        error_in_open_group <= error_in_open_group_next;
      end
    end
  end

endmodule

/* src/cfd_queue.sv */
module cfd_queue #(
  parameter int unsigned DEPTH = cfd_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  cfd_pkg::result_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output cfd_pkg::result_t  rd_data,
  output logic              not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  cfd_pkg::result_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr, do_rd;

  assign full      = count == CntW'(DEPTH);
  assign not_empty = count != '0;
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* src/cfd_back.sv */
module cfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  cfd_pkg::result_t  q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output cfd_pkg::result_t  res
);

  logic hold;

  assign q_rd  = q_not_empty && (!hold || pop);
  assign empty = !hold;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      res <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else begin
      hold <= q_not_empty || (hold && !pop);
    end
  end

endmodule

/* src/cobs_frame_decoder_core.sv */
// Streaming COBS decoder, one encoded byte per beat.
// Throughput: one input beat per cycle while full is low; one result beat
// per cycle while pop is high. A result reaches the output ports by the
// result queue write and then the output register load.
// Reset (rst, synchronous): frame state cleared, queue and output empty,
// output_capacity back to 65535.
module cobs_frame_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = cfd_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        frame_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        frame_end,
  output logic [1:0]  status
);

  logic             take;
  logic             res_push;
  cfd_pkg::result_t front_res;
  cfd_pkg::result_t q_data;
  logic             q_not_empty;
  logic             q_rd;
  cfd_pkg::result_t out_res;

  assign take = push && !full;

  cfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .in_byte     (in_byte),
    .frame_last  (frame_last),
    .res_push    (res_push),
    .res         (front_res)
  );

  cfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_push),
    .wr_data   (front_res),
    .full      (full),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .not_empty (q_not_empty)
  );

  cfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .res         (out_res)
  );

  assign out_byte  = out_res.out_byte;
  assign out_valid = out_res.out_valid;
  assign frame_end = out_res.frame_end;
  assign status    = out_res.status;

endmodule

/* tb/tb.sv */
class frame_decoder_check;
  logic [15:0] capacity;
  logic [7:0] group_left;
  bit prior_max;
  bit seen_code;
  bit open_group_err;
  logic [15:0] written;
  cfd_pkg::status_t err;
  cfd_pkg::result_t due_results[$];
  int errors;

  function new();
    capacity = cfd_pkg::CapacityReset;
    errors = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    group_left = 8'd0;
    prior_max = 1'b0;
    seen_code = 1'b0;
    written = 16'd0;
    err = cfd_pkg::ST_OK;
    open_group_err = 1'b0;
  endfunction

  // accepted input beat: advance the decoder state, queue the result it causes
  function void take_byte(logic [7:0] b, logic last);
    bit emit;
    bit go;
    logic [7:0] ob;
    cfd_pkg::result_t r;
    emit = 1'b0;
    ob = 8'd0;
    if (group_left != 8'd0) begin
      if (err == cfd_pkg::ST_OK) begin
        if (written >= capacity) begin
          err = cfd_pkg::ST_OVERFLOW;
          open_group_err = 1'b1;
        end else begin
          emit = 1'b1;
          ob = b;
          written = written + 16'd1;
        end
      end
      group_left = group_left - 8'd1;
      if (group_left == 8'd0) open_group_err = 1'b0;
    end else if (err == cfd_pkg::ST_OK) begin
      go = 1'b1;
      if (seen_code && !prior_max) begin
        if (written >= capacity) begin
          err = cfd_pkg::ST_OVERFLOW;
          go = 1'b0;
        end else begin
          emit = 1'b1;
          ob = cfd_pkg::CodeZero;
          written = written + 16'd1;
        end
      end
      if (go) begin
        if (b == cfd_pkg::CodeZero) begin
          err = cfd_pkg::ST_DECODE;
        end else begin
          group_left = b - 8'd1;
          prior_max = (b == cfd_pkg::CodeMax);
          seen_code = 1'b1;
        end
      end
    end
    if (last) begin
      if (group_left != 8'd0 && (err == cfd_pkg::ST_OK || open_group_err))
        err = cfd_pkg::ST_DECODE;
      r.out_byte = emit ? ob : 8'd0;
      r.out_valid = emit;
      r.frame_end = 1'b1;
      r.status = err;
      due_results.push_back(r);
      clear_frame();
    end else if (emit) begin
      r.out_byte = ob;
      r.out_valid = 1'b1;
      r.frame_end = 1'b0;
      r.status = cfd_pkg::ST_OK;
      due_results.push_back(r);
    end
  endfunction

  task report(string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task check_result(cfd_pkg::result_t got);
    cfd_pkg::result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("result with nothing due: byte=%0h valid=%0b end=%0b status=%0d",
                       got.out_byte, got.out_valid, got.frame_end, got.status));
      return;
    end
    want = due_results.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte %0h, want %0h", got.out_byte, want.out_byte));
    if (got.out_valid !== want.out_valid)
      report($sformatf("out_valid %0b, want %0b", got.out_valid, want.out_valid));
    if (got.frame_end !== want.frame_end)
      report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 140;
  localparam int LongHold = 200;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic push;
  logic full;
  logic [7:0] in_byte;
  logic frame_last;
  logic empty;
  logic pop;
  logic [7:0] out_byte;
  logic out_valid;
  logic frame_end;
  logic [1:0] status;

  frame_decoder_check sb = new();
  int cycles = 0;
  int items_sent = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;

  cobs_frame_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .frame_last(frame_last),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .out_valid(out_valid),
    .frame_end(frame_end),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task send_beat(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    frame_last <= last;
    do @(posedge clk); while (full !== 1'b0);
    sb.take_byte(b, last);
    items_sent++;
  endtask

  task send_frame(input byte_q_t enc);
    foreach (enc[i]) send_beat(enc[i], i == enc.size() - 1);
  endtask

  // mostly well-formed encodings of random data; some noise and broken frames
  task send_random_frame();
    byte_q_t data;
    byte_q_t blk;
    byte_q_t enc;
    int n;
    int kind;
    int zero_pct;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) enc.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 14) == 0) begin
        n = $urandom_range(250, 300);
        zero_pct = 0;
      end else begin
        n = $urandom_range(0, 20);
        zero_pct = $urandom_range(0, 40);
      end
      repeat (n)
        data.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)));
      foreach (data[i]) begin
        if (data[i] == cfd_pkg::CodeZero) begin
          enc.push_back(8'(blk.size() + 1));
          foreach (blk[j]) enc.push_back(blk[j]);
          blk.delete();
        end else begin
          blk.push_back(data[i]);
          if (blk.size() == 254) begin
            enc.push_back(cfd_pkg::CodeMax);
            foreach (blk[j]) enc.push_back(blk[j]);
            blk.delete();
          end
        end
      end
      enc.push_back(8'(blk.size() + 1));
      foreach (blk[j]) enc.push_back(blk[j]);
      if (kind < 25) begin
        if ($urandom_range(0, 1) == 0 && enc.size() > 1) begin
          cut = $urandom_range(1, (enc.size() - 1 < 3) ? enc.size() - 1 : 3);
          repeat (cut) void'(enc.pop_back());
        end else begin
          enc[$urandom_range(0, enc.size() - 1)] = cfd_pkg::CodeZero;
        end
      end
    end
    send_frame(enc);
  endtask

  task wait_idle();
    push <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_capacity(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.capacity = v;
  endtask

  initial begin
    int stall;
    cfd_pkg::result_t got;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      got.out_byte = out_byte;
      got.out_valid = out_valid;
      got.frame_end = frame_end;
      got.status = cfd_pkg::status_t'(status);
      sb.check_result(got);
    end
  end

  initial begin
    byte_q_t fq;
    logic [15:0] cap;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 16'd0;
    push <= 1'b0;
    in_byte <= 8'd0;
    frame_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset capacity
    fq = {8'h03, 8'h11, 8'hFF, 8'h02, 8'h33};
    send_frame(fq);
    fq = {8'h00};
    send_frame(fq);
    fq = {8'hFF, 8'h00, 8'h01};
    send_frame(fq);
    fq = {8'h02, 8'h05, 8'h01, 8'h00};
    send_frame(fq);
    fq = {8'h02};
    send_frame(fq);
    wait_idle();
    write_capacity(16'd1);
    fq = {8'h03, 8'hAA, 8'hBB};
    send_frame(fq);
    fq = {8'h02, 8'hAA, 8'h01};
    send_frame(fq);
    fq = {8'h04, 8'hAA, 8'hBB};
    send_frame(fq);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: cap = 16'd0;
        1: cap = 16'($urandom_range(1, 12));
        2: cap = 16'hFFFF;
        3: cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(13, 40));
      endcase
      wait_idle();
      write_capacity(cap);
      if (p == 2 || p == 4) hold_req = 1'b1;
      while (items_sent < 25 + PhaseItems * (p + 1)) send_random_frame();
    end
    wait_idle();

    if (sb.due_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

/* cobs_frame_decoder_core.f */
src/cfd_pkg.sv
src/cfd_front.sv
src/cfd_queue.sv
src/cfd_back.sv
src/cobs_frame_decoder_core.sv
tb/tb.sv
